[hw/rtl/psdl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psdl_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int KEY_W    = 32;
    localparam int COLOR_W  = 32;
    localparam int CORNER_W = 64;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic KIND_SHADOW = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DRAINED  = 2'd2;

    typedef struct packed {
        logic                kind;
        logic [COLOR_W-1:0]  color;
        logic [CORNER_W-1:0] corner0;
        logic [CORNER_W-1:0] corner1;
        logic [CORNER_W-1:0] corner2;
        logic [CORNER_W-1:0] corner3;
    } prim_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                entry_valid;
        logic [KEY_W-1:0]    priority_val;
        prim_t               prim;
        logic                last_of_run;
    } result_t;

    // shadows keep only the y word of corner zero
    function automatic prim_t make_prim(
        input logic                kind,
        input logic [COLOR_W-1:0]  color,
        input logic [CORNER_W-1:0] c0,
        input logic [CORNER_W-1:0] c1,
        input logic [CORNER_W-1:0] c2,
        input logic [CORNER_W-1:0] c3
    );
        prim_t p;
        p.kind  = kind;
        p.color = color;
        if (kind == KIND_SHADOW)
        begin
            p.corner0 = {{(CORNER_W/2){1'b0}}, c0[CORNER_W/2-1:0]};
            p.corner1 = '0;
            p.corner2 = '0;
            p.corner3 = '0;
        end
        else
        begin
            p.corner0 = c0;
            p.corner1 = c1;
            p.corner2 = c2;
            p.corner3 = c3;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/psdl_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface psdl_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic signed [psdl_pkg::KEY_W-1:0]    priority_req;
    logic                                 kind;
    logic [psdl_pkg::COLOR_W-1:0]         color_or_handle;
    logic [psdl_pkg::CORNER_W-1:0]        corner0_xy;
    logic [psdl_pkg::CORNER_W-1:0]        corner1_xy;
    logic [psdl_pkg::CORNER_W-1:0]        corner2_xy;
    logic [psdl_pkg::CORNER_W-1:0]        corner3_xy;

    modport source (
        output valid, operation, priority_req, kind, color_or_handle,
               corner0_xy, corner1_xy, corner2_xy, corner3_xy,
        input  ready
    );

    modport sink (
        input  valid, operation, priority_req, kind, color_or_handle,
               corner0_xy, corner1_xy, corner2_xy, corner3_xy,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/psdl_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface psdl_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [psdl_pkg::STATUS_W-1:0]        status;
    logic                                 entry_valid;
    logic signed [psdl_pkg::KEY_W-1:0]    out_priority;
    logic                                 out_kind;
    logic [psdl_pkg::COLOR_W-1:0]         out_color_or_handle;
    logic [psdl_pkg::CORNER_W-1:0]        out_corner0_xy;
    logic [psdl_pkg::CORNER_W-1:0]        out_corner1_xy;
    logic [psdl_pkg::CORNER_W-1:0]        out_corner2_xy;
    logic [psdl_pkg::CORNER_W-1:0]        out_corner3_xy;
    logic                                 last_of_run;

    modport source (
        output valid, status, entry_valid, out_priority, out_kind, out_color_or_handle,
               out_corner0_xy, out_corner1_xy, out_corner2_xy, out_corner3_xy,
               last_of_run,
        input  ready
    );

    modport sink (
        input  valid, status, entry_valid, out_priority, out_kind, out_color_or_handle,
               out_corner0_xy, out_corner1_xy, out_corner2_xy, out_corner3_xy,
               last_of_run,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/psdl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module psdl_ram #(
    parameter int WIDTH = psdl_pkg::KEY_W,
    parameter int DEPTH = psdl_pkg::CAPACITY_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/priority_sorted_display_list.sv]
// Display list of up to CAPACITY primitives kept in descending priority order
// (signed Q16.16, ties keep arrival order). One transaction is taken at a time.
// An insert is written to the next free slot in its accept cycle, then one
// shared signed comparator walks the linked list, one stored entry per cycle,
// until it finds a lower priority or the tail; S_FIX then relinks the
// predecessor if there is one, and S_RESP posts the result once the output
// register is free. An insert on an empty list skips the walk; a full list
// drops the insert. A drain posts one entry per cycle while the output is free
// (the link memory's registered read sets this pace); the list is then empty.
// The result register lets the next transaction be accepted while the last
// result waits to be taken. Storage is three single-port-write memories with
// registered reads (keys, links with end marks, primitive payload); none is
// cleared after reset, the walk only visits slots linked since the last drain.
`timescale 1ns / 1ps
`default_nettype none

module priority_sorted_display_list #(
    parameter int CAPACITY = psdl_pkg::CAPACITY_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    psdl_req_if.sink  request,
    psdl_res_if.source result
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = SW + 1;
    localparam int PW = $bits(psdl_pkg::prim_t);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_FIX   = 3'd2;
    localparam logic [2:0] S_RESP  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]                          state_reg, state_next;
    logic [SW-1:0]                       head_reg, head_next;
    logic                                nonempty_reg, nonempty_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [SW-1:0]                       cur_reg, cur_next;
    logic [SW-1:0]                       prev_reg, prev_next;
    logic                                has_prev_reg, has_prev_next;
    logic [SW-1:0]                       slot_reg, slot_next;
    logic signed [psdl_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [psdl_pkg::STATUS_W-1:0]       resp_reg, resp_next;
    logic                                out_valid_reg, out_valid_next;
    psdl_pkg::result_t                   out_res_reg, out_res_next;

    logic                                accept;
    logic                                out_free;
    logic                                full;
    logic [SW-1:0]                       free_slot;

    logic                                ram_re;
    logic [SW-1:0]                       ram_raddr;
    logic                                fill_we;
    logic                                link_we;
    logic [SW-1:0]                       link_waddr;
    logic [LW-1:0]                       link_wdata;
    logic [psdl_pkg::KEY_W-1:0]          key_rd;
    logic [LW-1:0]                       link_rd;
    psdl_pkg::prim_t                     prim_wdata;
    psdl_pkg::prim_t                     prim_rd;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign full          = (count_reg == CW'(CAPACITY));
    assign free_slot     = count_reg[SW-1:0];

    assign prim_wdata = psdl_pkg::make_prim(request.kind, request.color_or_handle,
                                            request.corner0_xy, request.corner1_xy,
                                            request.corner2_xy, request.corner3_xy);

    psdl_ram #(
        .WIDTH (psdl_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (free_slot),
        .wdata (request.priority_req),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (key_rd)
    );

    psdl_ram #(
        .WIDTH (PW),
        .DEPTH (CAPACITY)
    ) u_prim_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (free_slot),
        .wdata (prim_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (prim_rd)
    );

    // link word: end mark on top, next slot below
    psdl_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (link_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        nonempty_next  = nonempty_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        has_prev_next  = has_prev_reg;
        slot_next      = slot_reg;
        key_next       = key_reg;
        resp_next      = resp_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_res_next   = out_res_reg;
        ram_re         = 1'b0;
        ram_raddr      = cur_reg;
        fill_we        = 1'b0;
        link_we        = 1'b0;
        link_waddr     = slot_reg;
        link_wdata     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (request.operation)
                        psdl_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                resp_next  = psdl_pkg::ST_DROPPED;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                fill_we       = 1'b1;
                                link_we       = 1'b1;
                                link_waddr    = free_slot;
                                link_wdata    = {1'b1, {SW{1'b0}}};
                                slot_next     = free_slot;
                                key_next      = request.priority_req;
                                count_next    = count_reg + CW'(1);
                                resp_next     = psdl_pkg::ST_ACCEPTED;
                                if (!nonempty_reg)
                                begin
                                    head_next     = free_slot;
                                    nonempty_next = 1'b1;
                                    state_next    = S_RESP;
                                end
                                else
                                begin
                                    ram_re        = 1'b1;
                                    ram_raddr     = head_reg;
                                    cur_next      = head_reg;
                                    has_prev_next = 1'b0;
                                    state_next    = S_WALK;
                                end
                            end
                        end
                        psdl_pkg::OP_DRAIN:
                        begin
                            if (!nonempty_reg)
                            begin
                                resp_next     = psdl_pkg::ST_DRAINED;
                                head_next     = '0;
                                count_next    = '0;
                                state_next    = S_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                cur_next   = head_reg;
                                state_next = S_DRAIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (key_reg > $signed(key_rd))
                begin
                    link_we    = 1'b1;
                    link_waddr = slot_reg;
                    link_wdata = {1'b0, cur_reg};
                    if (has_prev_reg)
                    begin
                        state_next = S_FIX;
                    end
                    else
                    begin
                        head_next  = slot_reg;
                        state_next = S_RESP;
                    end
                end
                else if (link_rd[SW])
                begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg;
                    link_wdata = {1'b0, slot_reg};
                    state_next = S_RESP;
                end
                else
                begin
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    cur_next      = link_rd[SW-1:0];
                    ram_re        = 1'b1;
                    ram_raddr     = link_rd[SW-1:0];
                end
            end

            S_FIX:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = {1'b0, slot_reg};
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_res_next             = '0;
                    out_res_next.status      = resp_reg;
                    out_res_next.last_of_run = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_res_next.status       = psdl_pkg::ST_DRAINED;
                    out_res_next.entry_valid  = 1'b1;
                    out_res_next.priority_val = key_rd;
                    out_res_next.prim         = prim_rd;
                    out_res_next.last_of_run  = link_rd[SW];
                    if (link_rd[SW])
                    begin
                        head_next     = '0;
                        nonempty_next = 1'b0;
                        count_next    = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cur_next  = link_rd[SW-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = link_rd[SW-1:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            count_reg     <= '0;
            has_prev_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            count_reg     <= count_next;
            has_prev_reg  <= has_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        slot_reg    <= slot_next;
        key_reg     <= key_next;
        resp_reg    <= resp_next;
        out_res_reg <= out_res_next;
    end

    assign result.valid               = out_valid_reg;
    assign result.status              = out_res_reg.status;
    assign result.entry_valid         = out_res_reg.entry_valid;
    assign result.out_priority        = out_res_reg.priority_val;
    assign result.out_kind            = out_res_reg.prim.kind;
    assign result.out_color_or_handle = out_res_reg.prim.color;
    assign result.out_corner0_xy      = out_res_reg.prim.corner0;
    assign result.out_corner1_xy      = out_res_reg.prim.corner1;
    assign result.out_corner2_xy      = out_res_reg.prim.corner2;
    assign result.out_corner3_xy      = out_res_reg.prim.corner3;
    assign result.last_of_run         = out_res_reg.last_of_run;

endmodule

`default_nettype wire

[hw/rtl/psdl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module psdl_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [psdl_pkg::STATUS_W-1:0] res_status,
    input wire logic                          res_entry_valid,
    input wire logic                          res_last
);

    // a held result stays up until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    // one transaction at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a transaction was in work");

    // insert answers carry no entry and close their run
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == psdl_pkg::ST_ACCEPTED
                      || res_status == psdl_pkg::ST_DROPPED)
        |-> res_last && !res_entry_valid)
        else $error("insert result malformed");

    // entries only come out of a drain
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_entry_valid |-> res_status == psdl_pkg::ST_DRAINED)
        else $error("entry shown outside a drain");

endmodule

bind priority_sorted_display_list psdl_checker u_psdl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (request.valid),
    .req_ready       (request.ready),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_status      (result.status),
    .res_entry_valid (result.entry_valid),
    .res_last        (result.last_of_run)
);

`default_nettype wire
